### hdl/batt_pkg.sv
package batt_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int WINDOW_W = 31;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd604800000;

  // abs(delta)/1000 = (abs(delta) >> 3) / 125, and x / 125 = (x * RECIP) >> RECIP_SHIFT
  // exactly for every x below 2^28
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
  localparam int RECIP_SHIFT = 35;
  localparam int DIVIDEND_W  = 28;
  localparam int PROD_W      = DIVIDEND_W + RECIP_W;
  localparam int QUO_W       = 22;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_DATE = 1'b1;

  typedef struct packed {
    logic load;   // capture the accepted item
    logic find;   // register the table lookup
    logic put;    // write or refresh an entry
    logic diff;   // uptime difference and window check
    logic mul;    // reciprocal multiply
    logic emit;   // load the result register
  } batt_cmd_t;

  typedef struct packed {
    logic is_date;
    logic out_free;
  } batt_status_t;

endpackage

### hdl/batt_if.sv
interface batt_item_if;
  import batt_pkg::*;

  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] boot_number;
  logic [31:0] epoch_seconds;
  logic [31:0] uptime_ms;

  modport source (output valid, operation, boot_number, epoch_seconds, uptime_ms,
                  input ready);
  modport sink   (input valid, operation, boot_number, epoch_seconds, uptime_ms,
                  output ready);
endinterface

interface batt_result_if;
  import batt_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] unix_time;
  logic        approximate;
  logic        anchor_found;

  modport source (output valid, unix_time, approximate, anchor_found, input ready);
  modport sink   (input valid, unix_time, approximate, anchor_found, output ready);
endinterface

### hdl/batt_ctrl.sv
module batt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  batt_pkg::batt_status_t status,
  output batt_pkg::batt_cmd_t    cmd
);
  import batt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = status.is_date ? S_DIFF : S_PUT;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_IDLE;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_put_returns_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |=> state == S_IDLE)
    else $error("put did not return to idle");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a pending result");

endmodule

### hdl/batt_dp.sv
module batt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  batt_pkg::batt_cmd_t            cmd,
  output batt_pkg::batt_status_t         status,
  input  logic                          cfg_we,
  input  logic [batt_pkg::WINDOW_W-1:0] cfg_data,
  input  logic                          operation,
  input  logic [31:0]                   boot_number,
  input  logic [31:0]                   epoch_seconds,
  input  logic [31:0]                   uptime_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   unix_time,
  output logic                          approximate,
  output logic                          anchor_found
);
  import batt_pkg::*;

  logic [WINDOW_W-1:0] window;

  logic [31:0] tbl_boot   [ENTRIES];
  logic [31:0] tbl_epoch  [ENTRIES];
  logic [31:0] tbl_uptime [ENTRIES];
  logic [IDX_W-1:0] cursor;

  logic        op_q;
  logic [31:0] boot_q;
  logic [31:0] epoch_q;
  logic [31:0] up_q;

  logic             hit;
  logic [IDX_W-1:0] idx;
  logic             hit_q;
  logic [IDX_W-1:0] idx_q;

  logic [31:0] diff;
  logic [31:0] abs_diff;
  logic [31:0] abs_q;
  logic        neg_q;
  logic        win_q;
  logic [31:0] anc_epoch_q;

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_q;
  logic [31:0]       quo_ext;
  logic [31:0]       step_s;

  logic [IDX_W-1:0] put_idx;

  // lowest live entry for the boot wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_boot[i] == boot_q && tbl_epoch[i] != 32'd0) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  assign put_idx  = hit_q ? idx_q : cursor;
  assign diff     = up_q - tbl_uptime[idx_q];
  assign abs_diff = diff[31] ? (32'd0 - diff) : diff;
  assign prod     = PROD_W'(abs_q[DIVIDEND_W+2:3]) * PROD_W'(RECIP);
  assign quo_ext  = 32'(quo_q);
  assign step_s   = neg_q ? (32'd0 - quo_ext) : quo_ext;

  assign status.is_date  = (op_q == OP_DATE);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_epoch[i] <= 32'd0;
      end
    end else if (cmd.put) begin
      tbl_boot[put_idx]   <= boot_q;
      tbl_epoch[put_idx]  <= epoch_q;
      tbl_uptime[put_idx] <= up_q;
      if (!hit_q) begin
        cursor <= (cursor == IDX_W'(ENTRIES - 1)) ? '0 : cursor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      boot_q  <= boot_number;
      epoch_q <= epoch_seconds;
      up_q    <= uptime_ms;
    end
    if (cmd.find) begin
      hit_q <= hit;
      idx_q <= idx;
    end
    if (cmd.diff) begin
      abs_q       <= abs_diff;
      neg_q       <= diff[31];
      win_q       <= abs_diff < {1'b0, window};
      anc_epoch_q <= tbl_epoch[idx_q];
    end
    if (cmd.mul) begin
      quo_q <= prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
    end
    if (cmd.emit) begin
      anchor_found <= hit_q;
      approximate  <= !(hit_q && win_q);
      unix_time    <= (hit_q && win_q) ? anc_epoch_q + step_s : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= IDX_W'(ENTRIES - 1))
    else $error("write cursor beyond table");

  a_no_anchor_is_approx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !anchor_found |-> approximate)
    else $error("missing anchor not flagged approximate");

  a_approx_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && approximate |-> unix_time == 32'd0)
    else $error("approximate result carries a time");

endmodule

### hdl/boot_anchor_time_table_unit.sv
// Channel   Role   Payload                                               Transfer
// item      sink   operation, boot_number, epoch_seconds, uptime_ms      valid & ready
// result    source unix_time, approximate, anchor_found (dates only)     valid & ready
// cfg       write  cfg_data = date_window_ms                              cfg_we
//
// After a transfer, a put goes through the lookup and write steps before the next transfer;
// a date goes through the lookup, difference, reciprocal multiply and sum steps of the datapath.
// One item is in work at a time; the result register lets the next item start
// while a result waits, and a date stalls in its last step until that register frees.
// Synchronous reset empties the table, zeroes the cursor and loads the window default.
module boot_anchor_time_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [batt_pkg::WINDOW_W-1:0] cfg_data,
  batt_item_if.sink                     item,
  batt_result_if.source                 result
);
  import batt_pkg::*;

  batt_cmd_t    cmd;
  batt_status_t status;

  batt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  batt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .operation     (item.operation),
    .boot_number   (item.boot_number),
    .epoch_seconds (item.epoch_seconds),
    .uptime_ms     (item.uptime_ms),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .unix_time     (result.unix_time),
    .approximate   (result.approximate),
    .anchor_found  (result.anchor_found)
  );

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import batt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;
  localparam int POOL        = 10;

  typedef struct packed {
    logic [31:0] unix_time;
    logic        approximate;
    logic        anchor_found;
  } dated_t;

  typedef struct packed {
    logic        op;
    logic [31:0] boot;
    logic [31:0] epoch;
    logic [31:0] up;
    logic        typed;
    dated_t      want;
  } script_row_t;

  localparam dated_t NO_ANCHOR   = '{32'd0, 1'b1, 1'b0};
  localparam dated_t OUT_OF_SPAN = '{32'd0, 1'b1, 1'b1};
  localparam dated_t UNTYPED     = '0;

  localparam logic [31:0] SPAN_EDGE     = 32'(WINDOW_RESET);
  localparam logic [31:0] NEG_SPAN_EDGE = 32'd0 - SPAN_EDGE;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF          = 32'h8000_0000;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty table: every date misses
    '{OP_DATE, 32'd0,    32'd0,    32'd0,           1'b1, NO_ANCHOR},
    '{OP_DATE, ALL_ONES, 32'd0,    ALL_ONES,        1'b1, NO_ANCHOR},
    '{OP_PUT,  32'd5,    32'd1000, 32'd0,           1'b0, UNTYPED},
    '{OP_DATE, 32'd5,    32'd0,    32'd0,           1'b1, '{32'd1000, 1'b0, 1'b1}},
    '{OP_DATE, 32'd5,    32'd0,    32'd999,         1'b0, UNTYPED},
    '{OP_DATE, 32'd5,    32'd0,    ALL_ONES,        1'b0, UNTYPED},
    '{OP_DATE, 32'd5,    32'd0,    SPAN_EDGE - 1,   1'b0, UNTYPED},
    // span exactly at the window, both signs
    '{OP_DATE, 32'd5,    32'd0,    SPAN_EDGE,       1'b1, OUT_OF_SPAN},
    '{OP_DATE, 32'd5,    32'd0,    NEG_SPAN_EDGE,   1'b1, OUT_OF_SPAN},
    '{OP_PUT,  ALL_ONES, ALL_ONES, ALL_ONES,        1'b0, UNTYPED},
    '{OP_DATE, ALL_ONES, 32'd0,    32'h0000_1F3F,   1'b0, UNTYPED},
    // difference of -2^31 is never inside the window
    '{OP_DATE, ALL_ONES, 32'd0,    32'h7FFF_FFFF,   1'b1, OUT_OF_SPAN},
    // zero epoch empties the refreshed entry
    '{OP_PUT,  32'd5,    32'd0,    32'd0,           1'b0, UNTYPED},
    '{OP_DATE, 32'd5,    32'd0,    32'd0,           1'b1, NO_ANCHOR},
    '{OP_PUT,  32'd0,    32'd1,    HALF,            1'b0, UNTYPED},
    '{OP_DATE, 32'd0,    32'd0,    HALF,            1'b1, '{32'd1, 1'b0, 1'b1}},
    '{OP_DATE, 32'd0,    32'd0,    HALF - 32'd1000, 1'b0, UNTYPED},
    '{OP_PUT,  32'd5,    32'd7,    32'd12345,       1'b0, UNTYPED},
    // fill the table and wrap the cursor over the oldest slots
    '{OP_PUT,  32'd20,   32'd100,  32'd0,           1'b0, UNTYPED},
    '{OP_PUT,  32'd21,   32'd101,  32'd0,           1'b0, UNTYPED},
    '{OP_PUT,  32'd22,   32'd102,  32'd0,           1'b0, UNTYPED},
    '{OP_PUT,  32'd23,   32'd103,  32'd0,           1'b0, UNTYPED},
    '{OP_PUT,  32'd24,   32'd104,  32'd0,           1'b0, UNTYPED},
    '{OP_PUT,  32'd25,   32'd105,  32'd0,           1'b0, UNTYPED},
    '{OP_DATE, ALL_ONES, 32'd0,    32'd0,           1'b1, NO_ANCHOR}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [WINDOW_W-1:0] cfg_data;

  batt_item_if   item_ch ();
  batt_result_if result_ch ();

  boot_anchor_time_table_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // anchor table as the block should hold it
  logic [31:0]         tbl_boot   [ENTRIES];
  logic [31:0]         tbl_epoch  [ENTRIES];
  logic [31:0]         tbl_uptime [ENTRIES];
  int                  tbl_cursor;
  logic [WINDOW_W-1:0] window_ms;

  dated_t      dates_due [$];
  logic [31:0] boot_pool [POOL];

  int idle_pct;
  int stall_pct;
  int hold_asked;
  int cycles;
  int mismatches;
  int items_sent;
  int dates_checked;
  int approx_seen;
  int windows_set;

  function automatic int live_slot(input logic [31:0] boot);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_boot[i] == boot && tbl_epoch[i] != 32'd0)
        return i;
    return -1;
  endfunction

  // apply one item to the table copy; returns 1 when it yields a date result
  function automatic bit apply_to_table(input logic op, input logic [31:0] boot,
                                        input logic [31:0] epoch, input logic [31:0] up,
                                        output dated_t res);
    int          slot;
    logic [31:0] span;
    longint      delta;
    longint      win;
    slot = live_slot(boot);
    res = '0;
    if (op == OP_PUT) begin
      if (slot < 0) begin
        slot = tbl_cursor;
        tbl_boot[slot] = boot;
        tbl_cursor = (tbl_cursor + 1) % ENTRIES;
      end
      tbl_epoch[slot] = epoch;
      tbl_uptime[slot] = up;
      return 1'b0;
    end
    res.approximate = 1'b1;
    if (slot < 0)
      return 1'b1;
    res.anchor_found = 1'b1;
    span = up - tbl_uptime[slot];
    delta = longint'(signed'(span));
    win = longint'(window_ms);
    if (delta > -win && delta < win) begin
      res.unix_time = 32'(longint'(tbl_epoch[slot]) + delta / 1000);
      res.approximate = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tb: mismatch in %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic offer(input logic op, input logic [31:0] boot, input logic [31:0] epoch,
                       input logic [31:0] up, input logic typed, input dated_t typed_res);
    dated_t due;
    bit     yields;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.operation     <= op;
    item_ch.boot_number   <= boot;
    item_ch.epoch_seconds <= epoch;
    item_ch.uptime_ms     <= up;
    do @(posedge clk); while (!item_ch.ready);
    yields = apply_to_table(op, boot, epoch, up, due);
    if (typed)
      due = typed_res;
    if (yields)
      dates_due.push_back(due);
    items_sent++;
  endtask

  // uptime offset: mostly inside the window, some right at its edges, some anywhere
  function automatic longint span_offset();
    longint win;
    longint off;
    win = longint'(window_ms);
    case ($urandom_range(9)) inside
      [0:4]:   off = (win == 0) ? 0 : longint'($urandom) % (2 * win - 1) - (win - 1);
      5:       off = win;
      6:       off = (win == 0) ? 0 : win - 1;
      7:       off = longint'($urandom_range(6000)) - 3000;
      default: off = longint'($urandom);
    endcase
    if ($urandom_range(1) == 1)
      off = -off;
    return off;
  endfunction

  task automatic random_item();
    logic        op;
    logic [31:0] boot;
    logic [31:0] epoch;
    logic [31:0] up;
    int          slot;
    longint      off;
    op = ($urandom_range(99) < 35) ? OP_PUT : OP_DATE;
    boot = ($urandom_range(99) < 80) ? boot_pool[$urandom_range(POOL - 1)] : $urandom;
    epoch = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    if (op == OP_PUT) begin
      up = $urandom;
    end else begin
      slot = live_slot(boot);
      off = span_offset();
      up = ((slot >= 0) ? tbl_uptime[slot] : $urandom) + off[31:0];
    end
    offer(op, boot, epoch, up, 1'b0, UNTYPED);
  endtask

  task automatic wait_for_dates();
    while (dates_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] win);
    cfg_we   <= 1'b1;
    cfg_data <= win;
    @(posedge clk);
    cfg_we   <= 1'b0;
    window_ms = win;
    windows_set++;
  endtask

  task automatic run_phase(input logic [WINDOW_W-1:0] win, input int idle, input int stall,
                           input int count);
    wait_for_dates();
    // a trailing put may still be in work after the last result
    repeat (SETTLE) @(posedge clk);
    write_window(win);
    idle_pct = idle;
    stall_pct <= stall;
    boot_pool[0] = 32'd0;
    boot_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL; i++)
      boot_pool[i] = $urandom;
    repeat (count) random_item();
    if (count != 0)
      item_ch.valid <= 1'b0;
  endtask

  // result side: check each transfer, stall at random, hold off on request
  initial begin
    int     hold_seen;
    int     hold_left;
    dated_t got;
    dated_t want;
    hold_seen = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got = '{result_ch.unix_time, result_ch.approximate, result_ch.anchor_found};
        if (dates_due.size() == 0) begin
          flag("unexpected result", got.unix_time, 32'd0);
        end else begin
          want = dates_due.pop_front();
          if (got.unix_time !== want.unix_time)
            flag("unix_time", got.unix_time, want.unix_time);
          if (got.approximate !== want.approximate)
            flag("approximate", 32'(got.approximate), 32'(want.approximate));
          if (got.anchor_found !== want.anchor_found)
            flag("anchor_found", 32'(got.anchor_found), 32'(want.anchor_found));
        end
        dates_checked++;
        if (got.approximate === 1'b1)
          approx_seen++;
      end
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles,
               dates_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    dates_checked = 0;
    approx_seen = 0;
    windows_set = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_asked = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_boot[i] = '0;
      tbl_epoch[i] = '0;
      tbl_uptime[i] = '0;
    end
    tbl_cursor = 0;
    window_ms = WINDOW_RESET;

    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_data              <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.operation     <= OP_PUT;
    item_ch.boot_number   <= '0;
    item_ch.epoch_seconds <= '0;
    item_ch.uptime_ms     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run under the reset window
    for (int r = 0; r < SCRIPT_LEN; r++)
      offer(SCRIPT[r].op, SCRIPT[r].boot, SCRIPT[r].epoch, SCRIPT[r].up,
            SCRIPT[r].typed, SCRIPT[r].want);
    item_ch.valid <= 1'b0;

    run_phase(WINDOW_RESET,     0,  0,  80);
    run_phase(31'h7FFF_FFFF,    64, 0,  80);
    run_phase(31'd0,            0,  64, 60);
    run_phase(31'd1,            6,  6,  60);
    run_phase(31'd5000,         0,  0,  80);
    run_phase(31'($urandom),    64, 0,  80);

    // hold the result side off and keep offering items so that the input stalls
    run_phase(31'd20000, 0, 0, 0);
    hold_asked <= hold_asked + 1;
    repeat (24) random_item();
    item_ch.valid <= 1'b0;
    wait_for_dates();

    run_phase(WINDOW_RESET, 6, 6, 60);

    wait_for_dates();
    repeat (20) @(posedge clk);
    if (dates_due.size() != 0) begin
      $display("tb: %0d dates never arrived", dates_due.size());
      mismatches++;
    end
    $display("tb: %0d items sent, %0d dates checked (%0d approximate), %0d window settings",
             items_sent, dates_checked, approx_seen, windows_set);
    $display("tb: covered empty and evicted lookups, window edges, zero and full windows, "
             , "long result hold-off");
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hdl/batt_pkg.sv
hdl/batt_if.sv
hdl/batt_ctrl.sv
hdl/batt_dp.sv
hdl/boot_anchor_time_table_unit.sv
test/tb_top.sv
